/* design/lge_pkg.sv */
// shared types and constants of the life grid generation engine
`default_nettype none

package lge_pkg;

  // request type codes
  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_ADVANCE = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;

  localparam int unsigned CFG_W     = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // neighbour counts of the life rule
  localparam logic [3:0] LIFE_BIRTH = 4'd3;
  localparam logic [3:0] LIFE_KEEP  = 4'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       new_state;
  } lge_req_t;

  typedef struct packed {
    logic       read_state;
    logic       out_of_range;
    logic [1:0] done_kind;
  } lge_resp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_UPD,
    ST_ADV_PRIME0,
    ST_ADV_PRIME1,
    ST_ADV_LOAD,
    ST_ADV_CALC,
    ST_ADV_WRITE,
    ST_RESP
  } lge_state_e;

endpackage

`default_nettype wire

/* design/lge_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none

module lge_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* design/life_grid_generation_engine_core.sv */
// top level of the life grid generation engine: bounded game of life grid
//
// Requests arrive on in_valid_i/in_ready_o as an lge_req_t: write one cell,
// read one cell, or advance the grid in use by one generation. Each request
// gives one lge_resp_t on out_valid_o/out_ready_i. The rows_in_use and
// cols_in_use registers are written on the cfg channel, which is always ready.
// Both grid banks live in one ram of 2 x 2**$clog2(MAX_ROWS) row words; one row word
// holds MAX_COLS cells.
// After reset the block clears the current bank, one row per cycle, until
// all MAX_ROWS rows are clear; in_ready_o stays low meanwhile.
// A write or read does one ram read, then the update, which is skipped when
// out of range; any other request code gets a result with no action. An
// advance primes the row window, then for each row does one row load, runs
// the neighbour count unit over MAX_COLS cells, one cell per cycle, and does
// one row write-back.
// One request is worked on at a time. The result sits in an output register;
// while the receiver stalls the next request is taken and worked on, and it
// waits for the output register to free up before it completes.
`default_nettype none

module life_grid_generation_engine_core #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire lge_pkg::lge_req_t                  in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output lge_pkg::lge_resp_t                      out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [lge_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [lge_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned LW    = $clog2(MAX_ROWS + 2);
  localparam int unsigned CLW   = $clog2(MAX_COLS);
  localparam int unsigned CCW   = $clog2(MAX_COLS + 1);
  localparam int unsigned CW0   = (LW > CCW) ? LW : CCW;
  localparam int unsigned CW    = (CW0 > lge_pkg::CFG_W) ? CW0 : lge_pkg::CFG_W;
  localparam int unsigned AW    = RW + 1;
  localparam int unsigned DEPTH = 2 ** AW;

  lge_pkg::lge_state_e state_q, state_d;

  logic [lge_pkg::CFG_W-1:0] rows_q, cols_q;
  logic                      bank_q, bank_d;
  logic [RW-1:0]             crow_q, crow_d;
  logic [LW-1:0]             lrow_q, lrow_d;
  logic [LW-1:0]             rd_row_q;
  logic [CLW-1:0]            col_q, col_d;
  logic [2:0]                wl_q, wl_d;
  logic                      out_valid_q, out_valid_d;

  lge_pkg::lge_req_t  req_q, req_d;
  lge_pkg::lge_resp_t res_q, res_d;
  lge_pkg::lge_resp_t out_q, out_d;

  logic [MAX_COLS-1:0] prev_q, prev_d, cur_q, cur_d, nxt_q, nxt_d;
  logic [MAX_COLS-1:0] gen_q, gen_d;
  logic [MAX_COLS-1:0] colmask;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata, ram_rdata;

  logic in_accept, cell_op, in_range, row_ok, cell_ok, last_col, last_row, out_free;
  logic [2:0] center, right;
  logic [3:0] ncount;
  logic       next_cell;

  assign in_ready_o  = (state_q == lge_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_accept = in_valid_i && in_ready_o;
  assign cell_op   = (in_data_i.req_type == lge_pkg::REQ_WRITE) ||
                     (in_data_i.req_type == lge_pkg::REQ_READ);
  assign in_range  = (CW'(in_data_i.cell_row) < CW'(rows_q)) &&
                     (CW'(in_data_i.cell_row) < CW'(MAX_ROWS)) &&
                     (CW'(in_data_i.cell_col) < CW'(cols_q)) &&
                     (CW'(in_data_i.cell_col) < CW'(MAX_COLS));
  assign row_ok    = (CW'(rd_row_q) < CW'(rows_q)) && (CW'(rd_row_q) < CW'(MAX_ROWS));
  assign cell_ok   = (CW'(crow_q) < CW'(rows_q)) && (CW'(col_q) < CW'(cols_q));
  assign last_col  = (col_q == CLW'(MAX_COLS - 1));
  assign last_row  = (crow_q == RW'(MAX_ROWS - 1));
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      colmask[i] = CW'(i) < CW'(cols_q);
    end
  end

  // neighbour count and life rule for the cell at the window center
  always_comb begin
    center = {prev_q[0], cur_q[0], nxt_q[0]};
    right  = last_col ? 3'b000 : {prev_q[1], cur_q[1], nxt_q[1]};
    ncount = 4'(wl_q[2]) + 4'(wl_q[1]) + 4'(wl_q[0]) + 4'(center[2]) +
             4'(center[0]) + 4'(right[2]) + 4'(right[1]) + 4'(right[0]);
    if (ncount == lge_pkg::LIFE_BIRTH) begin
      next_cell = cell_ok;
    end else if (ncount == lge_pkg::LIFE_KEEP) begin
      next_cell = cell_ok && cur_q[0];
    end else begin
      next_cell = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lge_pkg::ST_CLEAR: begin
        if (last_row) state_d = lge_pkg::ST_IDLE;
      end
      lge_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_data_i.req_type)
            lge_pkg::REQ_WRITE,
            lge_pkg::REQ_READ:    state_d = in_range ? lge_pkg::ST_CELL_UPD : lge_pkg::ST_RESP;
            lge_pkg::REQ_ADVANCE: state_d = lge_pkg::ST_ADV_PRIME0;
            default:              state_d = lge_pkg::ST_RESP;
          endcase
        end
      end
      lge_pkg::ST_CELL_UPD:   state_d = lge_pkg::ST_RESP;
      lge_pkg::ST_ADV_PRIME0: state_d = lge_pkg::ST_ADV_PRIME1;
      lge_pkg::ST_ADV_PRIME1: state_d = lge_pkg::ST_ADV_LOAD;
      lge_pkg::ST_ADV_LOAD:   state_d = lge_pkg::ST_ADV_CALC;
      lge_pkg::ST_ADV_CALC: begin
        if (last_col) state_d = lge_pkg::ST_ADV_WRITE;
      end
      lge_pkg::ST_ADV_WRITE: begin
        state_d = last_row ? lge_pkg::ST_RESP : lge_pkg::ST_ADV_LOAD;
      end
      lge_pkg::ST_RESP: begin
        if (out_free) state_d = lge_pkg::ST_IDLE;
      end
      default: state_d = lge_pkg::ST_IDLE;
    endcase
  end

  // datapath, ram controls and outputs
  always_comb begin
    bank_d      = bank_q;
    crow_d      = crow_q;
    lrow_d      = lrow_q;
    col_d       = col_q;
    wl_d        = wl_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    gen_d       = gen_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = {bank_q, crow_q};
    ram_wdata   = '0;
    ram_raddr   = {bank_q, lrow_q[RW-1:0]};
    case (state_q)
      lge_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = {1'b0, crow_q};
        crow_d    = last_row ? '0 : crow_q + RW'(1);
      end
      lge_pkg::ST_IDLE: begin
        ram_raddr = {bank_q, RW'(in_data_i.cell_row)};
        if (in_accept) begin
          req_d              = in_data_i;
          res_d.read_state   = 1'b0;
          res_d.out_of_range = cell_op && !in_range;
          res_d.done_kind    = in_data_i.req_type;
          lrow_d             = '0;
          crow_d             = '0;
        end
      end
      lge_pkg::ST_CELL_UPD: begin
        if (req_q.req_type == lge_pkg::REQ_WRITE) begin
          ram_we    = 1'b1;
          ram_waddr = {bank_q, RW'(req_q.cell_row)};
          ram_wdata = ram_rdata;
          ram_wdata[CLW'(req_q.cell_col)] = req_q.new_state;
        end else begin
          res_d.read_state = ram_rdata[CLW'(req_q.cell_col)];
        end
      end
      lge_pkg::ST_ADV_PRIME0: begin
        prev_d = '0;
        cur_d  = '0;
        nxt_d  = '0;
        lrow_d = lrow_q + LW'(1);
      end
      lge_pkg::ST_ADV_PRIME1: begin
        prev_d = cur_q;
        cur_d  = nxt_q;
        nxt_d  = row_ok ? (ram_rdata & colmask) : '0;
        lrow_d = lrow_q + LW'(1);
      end
      lge_pkg::ST_ADV_LOAD: begin
        prev_d = cur_q;
        cur_d  = nxt_q;
        nxt_d  = row_ok ? (ram_rdata & colmask) : '0;
        col_d  = '0;
        wl_d   = '0;
      end
      lge_pkg::ST_ADV_CALC: begin
        // rows rotate so that bit 0 is the current column; after a full row
        // they are back in place for the next row
        wl_d   = center;
        prev_d = {prev_q[0], prev_q[MAX_COLS-1:1]};
        cur_d  = {cur_q[0], cur_q[MAX_COLS-1:1]};
        nxt_d  = {nxt_q[0], nxt_q[MAX_COLS-1:1]};
        gen_d  = {next_cell, gen_q[MAX_COLS-1:1]};
        col_d  = last_col ? '0 : col_q + CLW'(1);
      end
      lge_pkg::ST_ADV_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = {~bank_q, crow_q};
        ram_wdata = gen_q;
        if (last_row) begin
          bank_d = ~bank_q;
        end else begin
          crow_d = crow_q + RW'(1);
          lrow_d = lrow_q + LW'(1);
        end
      end
      lge_pkg::ST_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lge_pkg::ST_CLEAR;
      bank_q      <= 1'b0;
      crow_q      <= '0;
      lrow_q      <= '0;
      rd_row_q    <= '0;
      col_q       <= '0;
      wl_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      crow_q      <= crow_d;
      lrow_q      <= lrow_d;
      rd_row_q    <= lrow_q;
      col_q       <= col_d;
      wl_q        <= wl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= lge_pkg::CFG_RESET;
      cols_q <= lge_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lge_pkg::CFG_ROWS_IN_USE: rows_q <= cfg_data_i;
        lge_pkg::CFG_COLS_IN_USE: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    out_q  <= out_d;
    prev_q <= prev_d;
    cur_q  <= cur_d;
    nxt_q  <= nxt_d;
    gen_q  <= gen_d;
  end

  lge_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while a request is in progress");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lge_pkg::ST_IDLE) |-> !ram_we)
    else $error("grid written while idle");

  a_gen_to_other_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lge_pkg::ST_ADV_WRITE) |-> (ram_we && (ram_waddr[AW-1] != bank_q)))
    else $error("generation row not written to the other bank");

  a_bank_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bank_q != $past(bank_q)) |-> ($past(state_q) == lge_pkg::ST_ADV_WRITE))
    else $error("bank changed outside the end of an advance");

endmodule

`default_nettype wire

/* sim/life_grid_checker.sv */
// scoreboard for the life grid engine: mirrors the cell grid, predicts and checks each result
`timescale 1ns / 100ps

module life_grid_checker #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  lge_pkg::lge_req_t             in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  lge_pkg::lge_resp_t            out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [lge_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lge_pkg::CFG_W-1:0]     cfg_data_i,
  output int unsigned                   error_count_o,
  output int unsigned                   pending_o
);

  // only the current generation matters: an advance rewrites the other bank in full
  bit [GRID_COLS-1:0]        grid [GRID_ROWS];
  logic [lge_pkg::CFG_W-1:0] rows_reg;
  logic [lge_pkg::CFG_W-1:0] cols_reg;
  lge_pkg::lge_resp_t        expected_q [$];
  int unsigned               mismatches;

  function automatic int clip(logic [lge_pkg::CFG_W-1:0] n, int lim);
    return (int'(n) > lim) ? lim : int'(n);
  endfunction

  function automatic void next_generation();
    bit [GRID_COLS-1:0] nxt [GRID_ROWS];
    int rows, cols, n, rr, cc;
    rows = clip(rows_reg, GRID_ROWS);
    cols = clip(cols_reg, GRID_COLS);
    foreach (nxt[r]) nxt[r] = '0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            // cells past the region edge count as dead, no wrap-around
            if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < rows && cc < cols)
              n += grid[rr][cc];
          end
        end
        if (n == lge_pkg::LIFE_BIRTH) nxt[r][c] = 1'b1;
        else if (n == lge_pkg::LIFE_KEEP) nxt[r][c] = grid[r][c];
      end
    end
    grid = nxt;
  endfunction

  function automatic lge_pkg::lge_resp_t predict_result(lge_pkg::lge_req_t req);
    lge_pkg::lge_resp_t rsp;
    rsp = '0;
    rsp.done_kind = req.req_type;
    case (req.req_type)
      lge_pkg::REQ_WRITE, lge_pkg::REQ_READ: begin
        if (int'(req.cell_row) >= clip(rows_reg, GRID_ROWS) ||
            int'(req.cell_col) >= clip(cols_reg, GRID_COLS)) begin
          rsp.out_of_range = 1'b1;
        end else if (req.req_type == lge_pkg::REQ_WRITE) begin
          grid[req.cell_row][req.cell_col] = req.new_state;
        end else begin
          rsp.read_state = grid[req.cell_row][req.cell_col];
        end
      end
      lge_pkg::REQ_ADVANCE: next_generation();
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    lge_pkg::lge_resp_t want;
    if (!rst_ni) begin
      foreach (grid[r]) grid[r] = '0;
      rows_reg = lge_pkg::CFG_RESET;
      cols_reg = lge_pkg::CFG_RESET;
      expected_q.delete();
      mismatches = 0;
      error_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, expected none, actual %h",
                   $time, out_data_i);
        end else begin
          want = expected_q.pop_front();
          check_field("read_state", want.read_state, out_data_i.read_state);
          check_field("out_of_range", want.out_of_range, out_data_i.out_of_range);
          check_field("done_kind", want.done_kind, out_data_i.done_kind);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          lge_pkg::CFG_ROWS_IN_USE: rows_reg = cfg_data_i;
          lge_pkg::CFG_COLS_IN_USE: cols_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(predict_result(in_data_i));
      pending_o <= expected_q.size();
      error_count_o <= mismatches;
    end
  end

endmodule

/* sim/tb.sv */
// testbench top: drives cell and generation requests, region settings and result stalls into the life grid engine
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] REQ_NONE = 2'd3;  // unused request code, answered without action
  localparam int GRID_ROWS     = 64;
  localparam int GRID_COLS     = 64;
  localparam int STALL_LIMIT   = 50000;
  localparam int TAIL_CYCLES   = 20;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 19;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  lge_pkg::lge_req_t             in_data = '0;
  logic                          out_ready = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic [lge_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lge_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_ready;
  logic                          out_valid;
  logic                          cfg_ready;
  lge_pkg::lge_resp_t            out_data;
  int unsigned                   error_count;
  int unsigned                   pending;
  bit                            no_gaps = 1'b0;
  int                            span_rows = GRID_ROWS;
  int                            span_cols = GRID_COLS;
  int unsigned                   quiet_cycles = 0;

  always #5 clk = ~clk;

  life_grid_generation_engine_core #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  life_grid_checker #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS)
  ) grid_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    out_ready <= no_gaps || ($urandom_range(99) >= 35);
  end

  // a generation step is the longest quiet spell
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic lge_pkg::lge_req_t make_req(logic [1:0] kind, int row, int col, bit live);
    lge_pkg::lge_req_t r;
    r.req_type  = kind;
    r.cell_row  = row[5:0];
    r.cell_col  = col[5:0];
    r.new_state = live;
    return r;
  endfunction

  function automatic int pick_coord(int span);
    if (span > 0 && $urandom_range(9) != 0) return $urandom_range(span - 1);
    return $urandom_range(63);
  endfunction

  // valid stays up across back-to-back transfers; it only drops for a gap
  task automatic send_req(input lge_pkg::lge_req_t req);
    while (!no_gaps && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_region(int rows, int cols);
    wait_all_results();
    cfg_valid <= 1'b1;
    cfg_index <= lge_pkg::CFG_ROWS_IN_USE;
    cfg_data  <= rows[lge_pkg::CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= lge_pkg::CFG_COLS_IN_USE;
    cfg_data  <= cols[lge_pkg::CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    span_rows = (rows > GRID_ROWS) ? GRID_ROWS : rows;
    span_cols = (cols > GRID_COLS) ? GRID_COLS : cols;
  endtask

  // mostly seeding and probing inside the region, with generation steps mixed in
  task automatic random_phase(int count);
    lge_pkg::lge_req_t req;
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      req = make_req(lge_pkg::REQ_WRITE, pick_coord(span_rows), pick_coord(span_cols),
                     $urandom_range(99) < 60);
      if (pick >= 96) req.req_type = REQ_NONE;
      else if (pick >= 80) req.req_type = lge_pkg::REQ_ADVANCE;
      else if (pick >= 45) req.req_type = lge_pkg::REQ_READ;
      send_req(req);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty grid at full size, then lone cells that die out
    send_req(make_req(lge_pkg::REQ_READ, 0, 0, 1'b0));
    send_req(make_req(lge_pkg::REQ_WRITE, 63, 63, 1'b1));
    send_req(make_req(lge_pkg::REQ_READ, 63, 63, 1'b0));
    send_req(make_req(lge_pkg::REQ_WRITE, 0, 0, 1'b1));
    send_req(make_req(REQ_NONE, 63, 63, 1'b1));
    send_req(make_req(lge_pkg::REQ_ADVANCE, 0, 0, 1'b0));
    send_req(make_req(lge_pkg::REQ_READ, 0, 0, 1'b0));

    // blinker filling a 3 x 3 region, probes just past its edges
    set_region(3, 3);
    for (int c = 0; c < 3; c++) send_req(make_req(lge_pkg::REQ_WRITE, 1, c, 1'b1));
    send_req(make_req(lge_pkg::REQ_WRITE, 3, 1, 1'b1));
    send_req(make_req(lge_pkg::REQ_READ, 0, 3, 1'b0));
    send_req(make_req(lge_pkg::REQ_ADVANCE, 42, 21, 1'b1));
    send_req(make_req(lge_pkg::REQ_READ, 0, 1, 1'b0));
    send_req(make_req(lge_pkg::REQ_READ, 1, 0, 1'b0));

    // row count past the maximum, single column
    set_region(127, 1);
    for (int r = 61; r < 64; r++) send_req(make_req(lge_pkg::REQ_WRITE, r, 0, 1'b1));
    send_req(make_req(lge_pkg::REQ_READ, 5, 1, 1'b0));
    send_req(make_req(lge_pkg::REQ_ADVANCE, 0, 0, 1'b0));
    send_req(make_req(lge_pkg::REQ_READ, 62, 0, 1'b0));

    // empty region: every access is out of range and a step wipes the grid
    set_region(0, 64);
    send_req(make_req(lge_pkg::REQ_WRITE, 0, 0, 1'b1));
    send_req(make_req(lge_pkg::REQ_READ, 0, 0, 1'b0));
    send_req(make_req(lge_pkg::REQ_ADVANCE, 0, 0, 1'b0));
    set_region(64, 127);
    send_req(make_req(lge_pkg::REQ_READ, 62, 0, 1'b0));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(3))
        0: set_region($urandom_range(8, 1), $urandom_range(8, 1));
        1: set_region($urandom_range(24, 3), $urandom_range(24, 3));
        2: set_region($urandom_range(127, 64), $urandom_range(127, 64));
        default: set_region($urandom_range(127), $urandom_range(127));
      endcase
      no_gaps <= (p == 2);
      random_phase(PHASE_ITEMS);
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
design/lge_pkg.sv
design/lge_ram.sv
design/life_grid_generation_engine_core.sv
sim/life_grid_checker.sv
sim/tb.sv
